// ===== src/imh_pkg.sv =====
package imh_pkg;

  localparam int unsigned NODE_W = 10;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned OCC_W  = 11;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic STAT_DONE  = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node_index;
    logic [KEY_W-1:0]  key;
  } item_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] popped_node;
    logic              status;
    logic [OCC_W-1:0]  occupancy;
  } item_out_t;

endpackage

// ===== src/indexed_min_heap.sv =====
// sequence: a pop on an empty or one-entry heap, or a push with an out-of-range node, goes from S_START to S_DONE;
// otherwise each heap level checked takes a read state and a compare state, then S_FIN writes back
// throughput: one transaction at a time, set by the read-compare-write loop on the slot memory
// reset: synchronous, clears control state and occupancy, then a clearing pass over all NODES
// entries marks every node absent in the node memory with in_ready low
module indexed_min_heap #(
  parameter int unsigned NODES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imh_pkg::item_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imh_pkg::item_out_t  out_data
);

  localparam int unsigned IW  = $clog2(NODES);
  localparam int unsigned CW  = $clog2(NODES + 1);
  localparam int unsigned XW  = IW + 2;
  localparam int unsigned KW  = imh_pkg::KEY_W;
  localparam int unsigned HW  = IW + KW;
  localparam int unsigned NMW = IW + 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_START = 9'b000000100,
    S_UP_RD = 9'b000001000,
    S_UP_EV = 9'b000010000,
    S_DN_RD = 9'b000100000,
    S_DN_EV = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  imh_pkg::item_out_t out_data_r, out_data_nxt;
  logic               op_r, op_nxt;
  logic               range_r, range_nxt;
  logic               both_r, both_nxt;
  logic [IW-1:0]      cur_node_r, cur_node_nxt;
  logic [KW-1:0]      cur_key_r, cur_key_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      popped_r, popped_nxt;
  logic               status_r, status_nxt;

  logic               hp_we;
  logic [IW-1:0]      hp_waddr;
  logic [HW-1:0]      hp_wdata;
  logic [IW-1:0]      hp_ra_addr, hp_rb_addr;
  logic [HW-1:0]      hp_ra_data, hp_rb_data;

  logic               nd_we;
  logic [IW-1:0]      nd_waddr;
  logic [NMW-1:0]     nd_wdata;
  logic [NMW-1:0]     nd_rdata;

  logic [31:0]        in_node32;
  logic [IW-1:0]      in_node;
  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      parent;
  logic [XW-1:0]      left_x, right_x;
  logic               left_ok, right_ok;
  logic [IW-1:0]      a_node, b_node;
  logic [KW-1:0]      a_key, b_key;
  logic               take_l, take_r;
  logic [KW-1:0]      best_key;
  logic [31:0]        pop32, occ32;

  imh_slot_ram #(.DEPTH(NODES), .AW(IW), .DW(HW)) u_slot_ram (
    .clk     (clk),
    .we      (hp_we),
    .waddr   (hp_waddr),
    .wdata   (hp_wdata),
    .ra_addr (hp_ra_addr),
    .ra_data (hp_ra_data),
    .rb_addr (hp_rb_addr),
    .rb_data (hp_rb_data)
  );

  imh_node_ram #(.DEPTH(NODES), .AW(IW), .DW(NMW)) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (in_node),
    .rdata (nd_rdata)
  );

  assign in_node32 = 32'(in_data.node_index);
  assign in_node   = in_node32[IW-1:0];
  assign cnt_m1    = cnt_r - 1'b1;
  assign parent    = IW'((pos_r - 1'b1) >> 1);
  assign left_x    = {1'b0, pos_r, 1'b1};
  assign right_x   = left_x + 1'b1;
  assign left_ok   = left_x < XW'(cnt_r);
  assign right_ok  = right_x < XW'(cnt_r);
  assign a_node    = hp_ra_data[HW-1:KW];
  assign a_key     = hp_ra_data[KW-1:0];
  assign b_node    = hp_rb_data[HW-1:KW];
  assign b_key     = hp_rb_data[KW-1:0];
  assign take_l    = left_ok && (a_key < cur_key_r);
  assign best_key  = take_l ? a_key : cur_key_r;
  assign take_r    = right_ok && (b_key < best_key);
  assign pop32     = 32'(popped_r);
  assign occ32     = 32'(cnt_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    range_nxt     = range_r;
    both_nxt      = both_r;
    cur_node_nxt  = cur_node_r;
    cur_key_nxt   = cur_key_r;
    pos_nxt       = pos_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    hp_we         = 1'b0;
    hp_waddr      = pos_r;
    hp_wdata      = {cur_node_r, cur_key_r};
    hp_ra_addr    = '0;
    hp_rb_addr    = cnt_m1[IW-1:0];
    nd_we         = 1'b0;
    nd_waddr      = cur_node_r;
    nd_wdata      = {1'b1, pos_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        nd_we    = 1'b1;
        nd_waddr = clr_r;
        nd_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == IW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.action;
          range_nxt    = in_node32 < 32'(NODES);
          cur_node_nxt = in_node;
          cur_key_nxt  = in_data.key;
          popped_nxt   = '0;
          status_nxt   = imh_pkg::STAT_DONE;
          both_nxt     = 1'b0;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        if (op_r == imh_pkg::ACT_POP) begin
          if (cnt_r == '0) begin
            status_nxt = imh_pkg::STAT_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            popped_nxt   = a_node;
            nd_we        = 1'b1;
            nd_waddr     = a_node;
            nd_wdata     = '0;
            cnt_nxt      = cnt_m1;
            cur_node_nxt = b_node;
            cur_key_nxt  = b_key;
            pos_nxt      = '0;
            state_nxt    = (cnt_r == CW'(1)) ? S_DONE : S_DN_RD;
          end
        end else if (!range_r) begin
          state_nxt = S_DONE;
        end else if (!nd_rdata[IW]) begin
          pos_nxt   = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          pos_nxt   = nd_rdata[IW-1:0];
          both_nxt  = 1'b1;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        hp_ra_addr = parent;
        if (pos_r == '0) begin
          state_nxt = both_r ? S_DN_RD : S_FIN;
        end else begin
          state_nxt = S_UP_EV;
        end
      end
      S_UP_EV: begin
        if (a_key > cur_key_r) begin
          hp_we     = 1'b1;
          hp_waddr  = pos_r;
          hp_wdata  = hp_ra_data;
          nd_we     = 1'b1;
          nd_waddr  = a_node;
          nd_wdata  = {1'b1, pos_r};
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = both_r ? S_DN_RD : S_FIN;
        end
      end
      S_DN_RD: begin
        hp_ra_addr = left_x[IW-1:0];
        hp_rb_addr = right_x[IW-1:0];
        state_nxt  = left_ok ? S_DN_EV : S_FIN;
      end
      S_DN_EV: begin
        if (take_r) begin
          hp_we     = 1'b1;
          hp_waddr  = pos_r;
          hp_wdata  = hp_rb_data;
          nd_we     = 1'b1;
          nd_waddr  = b_node;
          nd_wdata  = {1'b1, pos_r};
          pos_nxt   = right_x[IW-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          hp_we     = 1'b1;
          hp_waddr  = pos_r;
          hp_wdata  = hp_ra_data;
          nd_we     = 1'b1;
          nd_waddr  = a_node;
          nd_wdata  = {1'b1, pos_r};
          pos_nxt   = left_x[IW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        hp_we     = 1'b1;
        nd_we     = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.popped_node = pop32[imh_pkg::NODE_W-1:0];
          out_data_nxt.status      = status_r;
          out_data_nxt.occupancy   = occ32[imh_pkg::OCC_W-1:0];
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    range_r    <= range_nxt;
    both_r     <= both_nxt;
    cur_node_r <= cur_node_nxt;
    cur_key_r  <= cur_key_nxt;
    pos_r      <= pos_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
  end

endmodule

// ===== src/imh_slot_ram.sv =====
module imh_slot_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 42
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] ra_addr,
  output logic [DW-1:0] ra_data,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] ra_data_r;
  logic [DW-1:0] rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data_r <= mem[ra_addr];
    rb_data_r <= mem[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

// ===== src/imh_node_ram.sv =====
module imh_node_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
